@@ src/lrcb_pkg.sv @@
// Shared types, constants and helper functions for the log row checker.
// No dependencies; every other file in src uses this package.
`timescale 1ns / 1ps

package lrcb_pkg;

	localparam int CountW  = 13;
	localparam int DigitW  = 5;
	localparam int RemW    = 17;
	localparam int WideW   = 20;
	localparam int CarryW  = 4;
	localparam int BucketW = 44;
	localparam int ByteW   = 8;

	localparam int unsigned SecPerDay = 86400;
	localparam int unsigned MaxCarry  = 9;

	localparam logic [CountW-1:0] CountSat   = '1;
	localparam logic [DigitW-1:0] DigitLimit = DigitW'(18);

	localparam logic [ByteW-1:0] ChTab     = 8'h09;
	localparam logic [ByteW-1:0] ChSpace   = 8'h20;
	localparam logic [ByteW-1:0] CtrlLimit = 8'h20;
	localparam logic [ByteW-1:0] ChZero    = 8'h30;
	localparam logic [ByteW-1:0] ChNine    = 8'h39;

	typedef struct packed {
		logic step;
		logic last;
	} lrcb_step_t;

	// Whole days contained in a value below ten days; each compare is independent.
	function automatic logic [CarryW-1:0] day_carry(input logic [WideW-1:0] t);
		logic [CarryW-1:0] k;
		k = '0;
		for (int unsigned j = 1; j <= MaxCarry; j++) begin
			if (t >= WideW'(j * SecPerDay)) k = CarryW'(j);
		end
		return k;
	endfunction

endpackage

@@ src/lrcb_if.sv @@
// Valid/ready channel interfaces for row bytes in and row results out.
// Depends on lrcb_pkg for the field widths.
`timescale 1ns / 1ps

interface lrcb_in_if;
	logic                      valid;
	logic                      ready;
	logic [lrcb_pkg::ByteW-1:0] row_byte;
	logic                      row_end;

	modport source (output valid, row_byte, row_end, input ready);
	modport sink   (input valid, row_byte, row_end, output ready);
endinterface

interface lrcb_out_if;
	logic                        valid;
	logic                        ready;
	logic                        row_valid;
	logic [lrcb_pkg::BucketW-1:0] day_bucket;

	modport source (output valid, row_valid, day_bucket, input ready);
	modport sink   (input valid, row_valid, day_bucket, output ready);
endinterface

@@ src/lrcb_day_acc.sv @@
// Leading-digit accumulator that tracks the running value as whole days plus
// a remainder in seconds, so the day bucket is ready without a divider. Uses lrcb_pkg.
`timescale 1ns / 1ps

module lrcb_day_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lrcb_pkg::lrcb_step_t         ctl,
	input  logic [lrcb_pkg::ByteW-1:0]   row_byte,
	output logic [lrcb_pkg::BucketW-1:0] quot_next
);
	import lrcb_pkg::*;

	logic               in_digits_q;
	logic [DigitW-1:0]  taken_q;
	logic [BucketW-1:0] quot_q;
	logic [RemW-1:0]    rem_q;

	logic               is_digit;
	logic [ByteW-1:0]   digit_diff;
	logic               take;
	logic [WideW-1:0]   wide;
	logic [CarryW-1:0]  carry;
	logic [WideW-1:0]   wide_left;
	logic [RemW-1:0]    rem_new;
	logic [BucketW-1:0] quot_new;

	// Value = quot * 86400 + rem. Appending a digit gives 10*quot*86400 + (10*rem + d),
	// and the second term holds at most nine whole days.
	always_comb begin
		is_digit   = (row_byte >= ChZero) && (row_byte <= ChNine);
		digit_diff = row_byte - ChZero;
		take       = in_digits_q && is_digit && (taken_q < DigitLimit);
		wide       = (WideW'(rem_q) << 3) + (WideW'(rem_q) << 1) + WideW'(digit_diff[3:0]);
		carry      = day_carry(wide);
		wide_left  = wide - WideW'(carry) * WideW'(SecPerDay);
		rem_new    = wide_left[RemW-1:0];
		quot_new   = (quot_q << 3) + (quot_q << 1) + BucketW'(carry);
		quot_next  = take ? quot_new : quot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_digits_q <= 1'b1;
			taken_q     <= '0;
			quot_q      <= '0;
			rem_q       <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				in_digits_q <= 1'b1;
				taken_q     <= '0;
				quot_q      <= '0;
				rem_q       <= '0;
			end else begin
				if (in_digits_q && !is_digit) in_digits_q <= 1'b0;
				if (take) begin
					taken_q <= taken_q + DigitW'(1);
					quot_q  <= quot_new;
					rem_q   <= rem_new;
				end
			end
		end
	end

endmodule

@@ src/log_row_check_and_bucket.sv @@
// Log row checker: one row byte per beat in, one result per row out.
// The final beat of a row is registered in the input stage and its result in the result
// register; the beat waits there while an earlier result is still waiting in the result register.
// Throughput: one byte beat per cycle, but a final beat is held while the result register is full.
// Reset clears the row state and sets bucketing_q to 1; no clearing pass is needed.
// Depends on lrcb_pkg, lrcb_in_if, lrcb_out_if and lrcb_day_acc.
`timescale 1ns / 1ps

module log_row_check_and_bucket #(
	parameter int ROW_MAX_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	lrcb_in_if.sink    rows,
	lrcb_out_if.source results,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import lrcb_pkg::*;

	localparam logic [CountW-1:0] MaxCount = CountW'(ROW_MAX_BYTES);

	logic               valid_s1;
	logic [ByteW-1:0]   byte_s1;
	logic               end_s1;

	logic [CountW-1:0]  count_q;
	logic               ctrl_q;
	logic               bucketing_q;

	logic               out_valid_q;
	logic               row_valid_q;
	logic [BucketW-1:0] bucket_q;

	logic               out_free;
	logic               adv_s1;
	logic [CountW-1:0]  count_next;
	logic               ctrl_next;
	logic               row_ok;
	logic [BucketW-1:0] quot_next;
	lrcb_step_t         acc_ctl;

	always_comb begin
		out_free   = !out_valid_q || results.ready;
		adv_s1     = valid_s1 && (!end_s1 || out_free);
		rows.ready = !valid_s1 || adv_s1;

		count_next = (count_q == CountSat) ? count_q : count_q + CountW'(1);
		ctrl_next  = ctrl_q || ((byte_s1 < CtrlLimit) && (byte_s1 != ChTab));
		row_ok     = (count_next >= CountW'(1)) && (count_next <= MaxCount) &&
		             (byte_s1 != ChSpace) && (byte_s1 != ChTab) && !ctrl_next;

		acc_ctl.step = adv_s1;
		acc_ctl.last = end_s1;
	end

	lrcb_day_acc u_day_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (acc_ctl),
		.row_byte  (byte_s1),
		.quot_next (quot_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucketing_q <= 1'b1;
		end else if (cfg_we) begin
			bucketing_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rows.ready) begin
			valid_s1 <= rows.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rows.valid && rows.ready) begin
			byte_s1 <= rows.row_byte;
			end_s1  <= rows.row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ctrl_q  <= 1'b0;
		end else if (adv_s1) begin
			if (end_s1) begin
				count_q <= '0;
				ctrl_q  <= 1'b0;
			end else begin
				count_q <= count_next;
				ctrl_q  <= ctrl_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && end_s1) begin
			row_valid_q <= row_ok;
			bucket_q    <= bucketing_q ? quot_next : '0;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.row_valid  = row_valid_q;
	assign results.day_bucket = bucket_q;

endmodule
